### rtl/fwrx_pkg.sv
// ----------------------------------------------------------------------------
// fwrx_pkg: shared types and constants for the firmware image receiver
// Operation codes, boot flag actions and the byte-wide reflected CRC-32 update.
// ----------------------------------------------------------------------------
package fwrx_pkg;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DATA  = 2'd1,
    OP_CHECK = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    BOOT_UNCHANGED = 2'd0,
    BOOT_SET       = 2'd1,
    BOOT_CLEAR     = 2'd2
  } boot_action_t;

  // Folds one byte into a reflected CRC-32; this unrolls into an XOR network.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data);
    logic [31:0] crc;
    crc = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      crc = (crc >> 1) ^ (CRC_POLY & {32{crc[0]}});
    end
    return crc;
  endfunction

endpackage

### rtl/fwrx_ifs.sv
// ----------------------------------------------------------------------------
// fwrx channel interfaces
// Valid/ready channels for upload requests and their results.
// ----------------------------------------------------------------------------
interface fwrx_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  data_byte;
  logic        batch_end;
  logic        flash_ok;
  logic [31:0] expected_crc;

  modport source (output valid, op, data_byte, batch_end, flash_ok, expected_crc,
                  input ready);
  modport sink (input valid, op, data_byte, batch_end, flash_ok, expected_crc,
                output ready);
endinterface

interface fwrx_res_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] write_address;
  logic [1:0]  boot_flag_action;
  logic [31:0] computed_crc;

  modport source (output valid, ok, write_address, boot_flag_action, computed_crc,
                  input ready);
  modport sink (input valid, ok, write_address, boot_flag_action, computed_crc,
                output ready);
endinterface

### rtl/firmware_image_receiver_crc32.sv
// ----------------------------------------------------------------------------
// firmware_image_receiver_crc32: upload session engine with running CRC-32
// Tracks one upload session, reports the flash address of each byte and
// checks the finished image against an expected reflected CRC-32.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake     Contents
//  request   in         valid/ready   op, data_byte, batch_end, flash_ok, expected_crc
//  result    out        valid/ready   ok, write_address, boot_flag_action, computed_crc
//  cfg       in         write enable  base_address
//
// The session state and the result register are both loaded at the edge that
// accepts a request, so the result shows in the next cycle. One request is
// accepted per cycle unless the result stalls; the byte-wide CRC XOR network sets
// the path. A stalled result blocks a new request only while it is still held.
// Synchronous reset closes the session, zeroes the address and presets the CRC.
module firmware_image_receiver_crc32 (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write_en,
  input  logic [31:0]     cfg_write_data,
  fwrx_req_if.sink        request,
  fwrx_res_if.source      result
);

  logic [31:0] base_address;
  logic        session_active;
  logic [31:0] next_address;
  logic [31:0] crc_register;

  logic        session_active_next;
  logic [31:0] next_address_next;
  logic [31:0] crc_register_next;
  logic        ok_next;
  logic [31:0] write_address_next;
  fwrx_pkg::boot_action_t action_next;

  logic        res_valid;
  logic        res_ok;
  logic [31:0] res_address;
  fwrx_pkg::boot_action_t res_action;
  logic [31:0] res_crc;

  logic        req_fire;

  assign request.ready = ~res_valid | result.ready;
  assign req_fire      = request.valid & request.ready;

  always_comb begin
    session_active_next = session_active;
    next_address_next   = next_address;
    crc_register_next   = crc_register;
    ok_next             = 1'b0;
    action_next         = fwrx_pkg::BOOT_UNCHANGED;
    case (fwrx_pkg::op_t'(request.op))
      fwrx_pkg::OP_START: begin
        if (request.flash_ok) begin
          session_active_next = 1'b1;
          next_address_next   = base_address;
          crc_register_next   = fwrx_pkg::CRC_INIT;
          ok_next             = 1'b1;
        end
      end
      fwrx_pkg::OP_DATA: begin
        if (session_active) begin
          if (request.flash_ok) begin
            crc_register_next = fwrx_pkg::crc_byte(crc_register, request.data_byte);
            next_address_next = next_address + 32'd1;
            ok_next           = 1'b1;
          end else begin
            session_active_next = 1'b0;
          end
        end
      end
      fwrx_pkg::OP_CHECK: begin
        if (session_active) begin
          if (~crc_register == request.expected_crc) begin
            ok_next     = 1'b1;
            action_next = fwrx_pkg::BOOT_SET;
          end else begin
            action_next = fwrx_pkg::BOOT_CLEAR;
          end
        end
      end
      default: begin
      end
    endcase
    // A data byte reports the address it was tried at; anything else reports
    // where the session stands afterwards.
    if ((fwrx_pkg::op_t'(request.op) == fwrx_pkg::OP_DATA) && session_active) begin
      write_address_next = next_address;
    end else begin
      write_address_next = next_address_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
    end else if (cfg_write_en) begin
      base_address <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      session_active <= 1'b0;
      next_address   <= '0;
      crc_register   <= fwrx_pkg::CRC_INIT;
    end else if (req_fire) begin
      session_active <= session_active_next;
      next_address   <= next_address_next;
      crc_register   <= crc_register_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (req_fire) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      res_ok      <= ok_next;
      res_address <= write_address_next;
      res_action  <= action_next;
      res_crc     <= ~crc_register_next;
    end
  end

  assign result.valid            = res_valid;
  assign result.ok               = res_ok;
  assign result.write_address    = res_address;
  assign result.boot_flag_action = res_action;
  assign result.computed_crc     = res_crc;

`ifndef SYNTHESIS
  // A successful erase always yields a successful result on the next cycle.
  a_start_ok: assert property (@(posedge clk) disable iff (rst)
    (req_fire && request.op == fwrx_pkg::OP_START && request.flash_ok)
      |=> (result.valid && result.ok))
    else $error("start with good erase did not report success");

  // Setting the boot flag only happens on a matching CRC.
  a_set_means_ok: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.boot_flag_action == fwrx_pkg::BOOT_SET) |-> result.ok)
    else $error("boot flag set without success");

  // A check outside a session never touches the boot flag.
  a_check_idle: assert property (@(posedge clk) disable iff (rst)
    (req_fire && request.op == fwrx_pkg::OP_CHECK && !session_active)
      |=> (result.boot_flag_action == fwrx_pkg::BOOT_UNCHANGED && !result.ok))
    else $error("check outside a session changed the boot flag");

  // The reported CRC always tracks the live CRC state.
  a_crc_tracks: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.computed_crc == ~crc_register))
    else $error("reported CRC differs from CRC state");
`endif

endmodule
